### design/frds_pkg.sv
// Package for the fractional divider ratio solver: codes, widths and helpers.
`timescale 1ns / 1ps
package frds_pkg;

   // Request kinds
   localparam logic [1:0] KIND_RECALC = 2'd0;
   localparam logic [1:0] KIND_ROUND  = 2'd1;
   localparam logic [1:0] KIND_SET    = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;   // unused, handled as recalc

   // Configuration register indexes
   localparam logic [1:0] CSR_MUL_WIDTH = 2'd0;
   localparam logic [1:0] CSR_DIV_WIDTH = 2'd1;
   localparam logic [1:0] CSR_DOUBLE    = 2'd2;
   localparam logic [1:0] CSR_EVEN      = 2'd3;

   localparam int RATE_W   = 32;
   localparam int FIELD_W  = 31;          // m and n storage width
   localparam int OPD_W    = 33;          // gcd operands, doubled target
   localparam int QUO_W    = 64;          // divider quotient register
   localparam int NARROW_N = 34;          // steps for a narrow divide
   localparam int CNT_W    = 7;

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   // Divider command
   typedef struct packed {
      logic start;
      logic wide;
   } div_cmd_type;

   // (1 << w) - 1 over the field storage width
   function automatic logic [FIELD_W-1:0] field_mask(input logic [4:0] w);
      logic [FIELD_W:0] one_sh;
      one_sh = {{FIELD_W{1'b0}}, 1'b1} << w;
      return FIELD_W'(one_sh - {{FIELD_W{1'b0}}, 1'b1});
   endfunction

endpackage

### design/frds_divider.sv
// Shared restoring divider: one quotient bit per cycle, narrow or wide dividend.
`timescale 1ns / 1ps
module frds_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  frds_pkg::div_cmd_type         cmd,
   input  logic [frds_pkg::QUO_W-1:0]    dividend,
   input  logic [frds_pkg::OPD_W-1:0]    divisor,
   output logic                          done,
   output logic [frds_pkg::QUO_W-1:0]    quotient,
   output logic [frds_pkg::OPD_W-1:0]    remainder
);

   logic [frds_pkg::QUO_W-1:0] q_ff, q_in;
   logic [frds_pkg::OPD_W-1:0] r_ff, r_in;
   logic [frds_pkg::OPD_W-1:0] d_ff, d_in;
   logic [frds_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       done_ff, done_in;
   logic [frds_pkg::OPD_W:0]   shifted;
   logic [frds_pkg::OPD_W+1:0] diff;

   // one compare-subtract step
   assign shifted = {r_ff, q_ff[frds_pkg::QUO_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, d_ff};

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         d_in = divisor;
         r_in = '0;
         if (cmd.wide) begin
            q_in   = dividend;
            cnt_in = frds_pkg::CNT_W'(frds_pkg::QUO_W);
         end else begin
            q_in   = {dividend[frds_pkg::NARROW_N-1:0],
                      {(frds_pkg::QUO_W-frds_pkg::NARROW_N){1'b0}}};
            cnt_in = frds_pkg::CNT_W'(frds_pkg::NARROW_N);
         end
      end else if (cnt_ff != '0) begin
         if (diff[frds_pkg::OPD_W+1]) begin
            r_in = shifted[frds_pkg::OPD_W-1:0];
            q_in = {q_ff[frds_pkg::QUO_W-2:0], 1'b0};
         end else begin
            r_in = diff[frds_pkg::OPD_W-1:0];
            q_in = {q_ff[frds_pkg::QUO_W-2:0], 1'b1};
         end
         cnt_in  = cnt_ff - frds_pkg::CNT_W'(1);
         done_in = (cnt_ff == frds_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

### design/fractional_divider_ratio_solver_core.sv
// Top level of the fractional divider m/n solver: sequencer, state and ports.
`timescale 1ns / 1ps
// One request at a time; req_tready is high only when the block is idle.
// All division runs through one shared restoring divider, one bit a cycle,
// for the narrow divides (gcd step, m, n) and the final 64-bit rate divide.
// Set and round run Euclid remainder steps, then two narrow divides; round
// then halves m and n, one bit a cycle, until the ratio fits the widths.
// A round request whose target is zero or not below the parent shows its
// result the cycle after it is accepted.
module fractional_divider_ratio_solver_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // target_rate[31:0], src_rate[63:32]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // result_rate[31:0], ratio_num[63:32], ratio_den[95:64]
   output logic [0:0]  rsp_tuser,   // zero_divide[0]
   // configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_wdata
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_GCD  = 9'b000000010,
      S_GCDW = 9'b000000100,
      S_QM   = 9'b000001000,
      S_QN   = 9'b000010000,
      S_ADJ  = 9'b000100000,
      S_MUL  = 9'b001000000,
      S_RCHK = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   localparam int FW = frds_pkg::FIELD_W;
   localparam int OW = frds_pkg::OPD_W;

   state_type             state_ff, state_in;
   logic [4:0]            mw_ff, mw_in, nw_ff, nw_in;
   logic                  dd_ff, dd_in, em_ff, em_in;
   logic [FW-1:0]         sm_ff, sm_in, sn_ff, sn_in;
   logic [1:0]            kind_ff, kind_in;
   logic [OW-1:0]         tgt_ff, tgt_in;
   logic [31:0]           par_ff, par_in;
   logic [OW-1:0]         a_ff, a_in, b_ff, b_in;
   logic [OW:0]           m_ff, m_in;
   logic [OW-1:0]         n_ff, n_in;
   logic [62:0]           prod_ff, prod_in;
   logic [31:0]           rate_ff, rate_in, num_ff, num_in, den_ff, den_in;
   logic                  zd_ff, zd_in;

   frds_pkg::div_cmd_type  cmd;
   logic [frds_pkg::QUO_W-1:0] div_dividend, div_quo;
   logic [OW-1:0]         div_divisor, div_rem;
   logic                  div_done;

   logic [31:0]           in_tgt, in_par;
   logic [1:0]            in_kind;
   logic [OW:0]           cand_m;
   logic [OW-1:0]         cand_n;
   logic                  make_even;
   logic [FW-1:0]         mmask, nmask;
   logic [31:0]           rate_den;

   assign in_tgt  = req_tdata[31:0];
   assign in_par  = req_tdata[63:32];
   assign in_kind = req_tuser;

   assign mmask     = frds_pkg::field_mask(mw_ff);
   assign nmask     = frds_pkg::field_mask(nw_ff);
   assign make_even = em_ff && m_ff[0];
   assign cand_m    = make_even ? {m_ff[OW-1:0], 1'b0} : m_ff;
   assign cand_n    = make_even ? {n_ff[OW-2:0], 1'b0} : n_ff;
   assign rate_den  = dd_ff ? {n_ff[FW-1:0], 1'b0} : {1'b0, n_ff[FW-1:0]};

   frds_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      mw_in = mw_ff; nw_in = nw_ff; dd_in = dd_ff; em_in = em_ff;
      sm_in = sm_ff; sn_in = sn_ff;
      kind_in = kind_ff; tgt_in = tgt_ff; par_in = par_ff;
      a_in = a_ff; b_in = b_ff; m_in = m_ff; n_in = n_ff;
      prod_in = prod_ff;
      rate_in = rate_ff; num_in = num_ff; den_in = den_ff; zd_in = zd_ff;
      cmd = '0;
      div_dividend = '0;
      div_divisor  = '0;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            frds_pkg::CSR_MUL_WIDTH: mw_in = csr_wdata;
            frds_pkg::CSR_DIV_WIDTH: nw_in = csr_wdata;
            frds_pkg::CSR_DOUBLE:    dd_in = csr_wdata[0];
            frds_pkg::CSR_EVEN:      em_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = in_kind;
               par_in  = in_par;
               tgt_in  = (dd_ff && (in_kind == frds_pkg::KIND_SET ||
                                    in_kind == frds_pkg::KIND_ROUND))
                         ? {in_tgt, 1'b0} : {1'b0, in_tgt};
               // larger operand in a, smaller in b
               if (in_kind == frds_pkg::KIND_SET || in_kind == frds_pkg::KIND_ROUND) begin
                  logic [OW-1:0] t2;
                  t2 = dd_ff ? {in_tgt, 1'b0} : {1'b0, in_tgt};
                  if (t2 < {1'b0, in_par}) begin
                     a_in = {1'b0, in_par}; b_in = t2;
                  end else begin
                     a_in = t2; b_in = {1'b0, in_par};
                  end
               end
               if (in_kind == frds_pkg::KIND_SET) begin
                  state_in = S_GCD;
               end else if (in_kind == frds_pkg::KIND_ROUND) begin
                  if (in_tgt == '0 || in_tgt >= in_par) begin
                     rate_in = in_par; num_in = '0; den_in = '0; zd_in = 1'b0;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_GCD;
                  end
               end else begin
                  m_in = {{(OW+1-FW){1'b0}}, sm_ff};
                  n_in = {{(OW-FW){1'b0}}, sn_ff};
                  state_in = S_MUL;
               end
            end
         end
         // Euclid: a % b until b is zero
         S_GCD: begin
            if (b_ff != '0) begin
               cmd.start    = 1'b1;
               div_dividend = {{(frds_pkg::QUO_W-OW){1'b0}}, a_ff};
               div_divisor  = b_ff;
               state_in     = S_GCDW;
            end else if (a_ff == '0) begin
               rate_in = '0; num_in = '0; den_in = '0; zd_in = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.start    = 1'b1;
               div_dividend = {{(frds_pkg::QUO_W-OW){1'b0}}, tgt_ff};
               div_divisor  = a_ff;
               state_in     = S_QM;
            end
         end
         S_GCDW: begin
            if (div_done) begin
               a_in = b_ff;
               b_in = div_rem;
               state_in = S_GCD;
            end
         end
         // m = target / g, then n = parent / g
         S_QM: begin
            if (div_done) begin
               m_in = {1'b0, div_quo[OW-1:0]};
               cmd.start    = 1'b1;
               div_dividend = {{(frds_pkg::QUO_W-32){1'b0}}, par_ff};
               div_divisor  = a_ff;
               state_in     = S_QN;
            end
         end
         S_QN: begin
            if (div_done) begin
               n_in = {1'b0, div_quo[31:0]};
               state_in = S_ADJ;
            end
         end
         // set: even fixup and mask; round: even fixup, halve until the ratio fits
         S_ADJ: begin
            if (kind_ff == frds_pkg::KIND_SET) begin
               sm_in = cand_m[FW-1:0] & mmask;
               sn_in = cand_n[FW-1:0] & nmask;
               m_in  = {{(OW+1-FW){1'b0}}, cand_m[FW-1:0] & mmask};
               n_in  = {{(OW-FW){1'b0}}, cand_n[FW-1:0] & nmask};
               state_in = S_MUL;
            end else if (cand_m <= {{(OW+1-FW){1'b0}}, mmask} &&
                         cand_n <= {{(OW-FW){1'b0}}, nmask}) begin
               m_in = cand_m;
               n_in = cand_n;
               state_in = S_MUL;
            end else begin
               m_in = m_ff >> 1;
               n_in = n_ff >> 1;
            end
         end
         S_MUL: begin
            prod_in  = 63'(par_ff) * 63'(m_ff[FW-1:0]);
            num_in   = {1'b0, m_ff[FW-1:0]};
            den_in   = {1'b0, n_ff[FW-1:0]};
            state_in = S_RCHK;
         end
         // rate = parent * m / den, saturated
         S_RCHK: begin
            if (rate_den == '0) begin
               rate_in = '0; zd_in = 1'b1;
               state_in = S_OUT;
            end else if (!cmd.start && div_done) begin
               rate_in = (div_quo[63:32] != '0) ? frds_pkg::RATE_MAX : div_quo[31:0];
               zd_in = 1'b0;
               state_in = S_OUT;
            end else if (zd_ff) begin
               // first cycle here: launch the divide, flag marks it pending
               cmd.start    = 1'b1;
               cmd.wide     = 1'b1;
               div_dividend = {1'b0, prod_ff};
               div_divisor  = {1'b0, rate_den};
               zd_in        = 1'b0;
            end
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // zd doubles as the "divide not launched yet" mark on entry to S_RCHK
      if (state_ff == S_MUL) zd_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mw_ff    <= 5'd8;
         nw_ff    <= 5'd8;
         dd_ff    <= 1'b0;
         em_ff    <= 1'b0;
         sm_ff    <= '0;
         sn_ff    <= '0;
      end else begin
         state_ff <= state_in;
         mw_ff    <= mw_in;
         nw_ff    <= nw_in;
         dd_ff    <= dd_in;
         em_ff    <= em_in;
         sm_ff    <= sm_in;
         sn_ff    <= sn_in;
      end
      kind_ff <= kind_in;
      tgt_ff  <= tgt_in;
      par_ff  <= par_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      m_ff    <= m_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
      rate_ff <= rate_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      zd_ff   <= zd_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {den_ff, num_ff, rate_ff};
   assign rsp_tuser  = zd_ff;

endmodule

### dv/tb_top.sv
// Testbench for the fractional divider ratio solver: directed table and random requests.
`timescale 1ns / 1ps
module tb_top;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // target_rate[31:0], src_rate[63:32]
   logic [1:0]  req_tuser;    // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;    // result_rate[31:0], ratio_num[63:32], ratio_den[95:64]
   logic [0:0]  rsp_tuser;    // zero_divide[0]
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [4:0]  csr_wdata;

   typedef struct packed {
      logic [31:0] rate;
      logic [31:0] num;
      logic [31:0] den;
      logic        zdiv;
   } ratio_word_type;

   typedef struct {
      logic [1:0]     kind;
      logic [31:0]    target;
      logic [31:0]    parent;
      logic           has_exp;
      ratio_word_type exp;
   } stim_row_type;

   fractional_divider_ratio_solver_core u_dut (.*);

   // predictor copy of configuration and ratio state
   logic [4:0]  mul_w, div_w;
   logic        dbl_mode, even_mode;
   logic [63:0] cur_m, cur_n;

   ratio_word_type ratio_q[$];
   int             errors;
   bit             quiet_req, quiet_rsp;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("fractional_divider_ratio_solver_core verification failed");
      $finish;
   end

   function automatic logic [63:0] width_mask(input logic [4:0] w);
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      if (a < b) begin
         t = a; a = b; b = t;
      end
      while (b != 0) begin
         t = a % b; a = b; b = t;
      end
      return a;
   endfunction

   function automatic ratio_word_type rate_for(input logic [63:0] p, input logic [63:0] m,
                                               input logic [63:0] n);
      ratio_word_type r;
      logic [63:0] d, q;
      d = dbl_mode ? 2 * n : n;
      r.num = m[31:0];
      r.den = n[31:0];
      if (d == 0) begin
         r.rate = '0; r.zdiv = 1'b1;
      end else begin
         q = (p * m) / d;
         r.rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         r.zdiv = 1'b0;
      end
      return r;
   endfunction

   // expected result of one request; updates stored ratio on set
   function automatic ratio_word_type solve_ratio(input logic [1:0] kind,
                                                  input logic [31:0] tgt,
                                                  input logic [31:0] par);
      logic [63:0] t, p, g, m, n;
      ratio_word_type r;
      t = {32'd0, tgt};
      p = {32'd0, par};
      if (kind == frds_pkg::KIND_SET) begin
         if (dbl_mode) t = t * 2;
         g = gcd64(p, t);
         if (g == 0) begin
            r = '{rate: 0, num: 0, den: 0, zdiv: 1'b1};
            return r;
         end
         m = t / g; n = p / g;
         if (even_mode && m[0]) begin
            m = m * 2; n = n * 2;
         end
         cur_m = m & width_mask(mul_w);
         cur_n = n & width_mask(div_w);
         return rate_for(p, cur_m, cur_n);
      end
      if (kind == frds_pkg::KIND_ROUND) begin
         if (t == 0 || t >= p) begin
            r = '{rate: par, num: 0, den: 0, zdiv: 1'b0};
            return r;
         end
         if (dbl_mode) t = t * 2;
         g = gcd64(p, t);
         forever begin
            m = t / g; n = p / g;
            if (even_mode && m[0]) begin
               m = m * 2; n = n * 2;
            end
            if (m <= width_mask(mul_w) && n <= width_mask(div_w)) break;
            g = g << 1;
         end
         return rate_for(p, m, n);
      end
      return rate_for(p, cur_m, cur_n);
   endfunction

   // write one register between phases
   task automatic write_csr(input logic [1:0] idx, input logic [4:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         frds_pkg::CSR_MUL_WIDTH: mul_w     = val;
         frds_pkg::CSR_DIV_WIDTH: div_w     = val;
         frds_pkg::CSR_DOUBLE:    dbl_mode  = val[0];
         default:                 even_mode = val[0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [4:0] mw, input logic [4:0] nw,
                             input logic dbl, input logic evn);
      while (ratio_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(frds_pkg::CSR_MUL_WIDTH, mw);
      write_csr(frds_pkg::CSR_DIV_WIDTH, nw);
      write_csr(frds_pkg::CSR_DOUBLE, {4'd0, dbl});
      write_csr(frds_pkg::CSR_EVEN, {4'd0, evn});
   endtask

   // send one request word; predict its result on acceptance
   task automatic send_req(input logic [1:0] kind, input logic [31:0] tgt,
                           input logic [31:0] par, input logic has_exp,
                           input ratio_word_type fixed);
      ratio_word_type pred;
      while (!quiet_req && $urandom_range(99) < 25) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {par, tgt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = solve_ratio(kind, tgt, par);
      if (has_exp && pred != fixed)
         $display("%0t table row disagrees with predictor: table %h predictor %h",
                  $time, fixed, pred);
      ratio_q.push_back(has_exp ? fixed : pred);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_rate(input int sel);
      case (sel)
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1000);
         3: return $urandom_range(100_000_000);
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      ratio_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser[0]};
         if (ratio_q.size() == 0) begin
            $display("%0t unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = ratio_q.pop_front();
            if (got.rate != want.rate) begin
               $display("%0t result_rate expected %h actual %h", $time, want.rate, got.rate);
               errors++;
            end
            if (got.num != want.num) begin
               $display("%0t ratio_num expected %h actual %h", $time, want.num, got.num);
               errors++;
            end
            if (got.den != want.den) begin
               $display("%0t ratio_den expected %h actual %h", $time, want.den, got.den);
               errors++;
            end
            if (got.zdiv != want.zdiv) begin
               $display("%0t zero_divide expected %b actual %b", $time, want.zdiv, got.zdiv);
               errors++;
            end
         end
      end
   end

   // result-side stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet_rsp || ($urandom_range(99) >= 25);
   end

   stim_row_type dir_tab[$];

   initial begin
      int          i, k, waited;
      logic [1:0]  kind;
      logic [31:0] t, p;
      errors = 0; quiet_req = 0; quiet_rsp = 0;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      mul_w = 5'd8; div_w = 5'd8; dbl_mode = 1'b0; even_mode = 1'b0;
      cur_m = 0; cur_n = 0;

      // directed rows: fixed values only where obvious
      dir_tab = '{
         '{frds_pkg::KIND_RECALC, 32'd0, 32'd1000, 1, '{0, 0, 0, 1'b1}},
         '{frds_pkg::KIND_SET, 32'd0, 32'd0, 1, '{0, 0, 0, 1'b1}},
         '{frds_pkg::KIND_ROUND, 32'd0, 32'd777, 1, '{32'd777, 0, 0, 1'b0}},
         '{frds_pkg::KIND_ROUND, 32'd900, 32'd900, 1, '{32'd900, 0, 0, 1'b0}},
         '{frds_pkg::KIND_ROUND, 32'hFFFF_FFFF, 32'd5, 1, '{32'd5, 0, 0, 1'b0}},
         '{frds_pkg::KIND_SET, 32'd3, 32'd4, 1, '{32'd3, 32'd3, 32'd4, 1'b0}},
         '{frds_pkg::KIND_RECALC, 32'd0, 32'd400, 1, '{32'd300, 32'd3, 32'd4, 1'b0}},
         '{frds_pkg::KIND_SPARE, 32'hFFFF_FFFF, 32'd8, 1, '{32'd6, 32'd3, 32'd4, 1'b0}},
         '{frds_pkg::KIND_SET, 32'd5, 32'd0, 0, '0},
         '{frds_pkg::KIND_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, '0},
         '{frds_pkg::KIND_RECALC, 32'd0, 32'hFFFF_FFFF, 0, '0},
         '{frds_pkg::KIND_ROUND, 32'd1, 32'hFFFF_FFFF, 0, '0},
         '{frds_pkg::KIND_ROUND, 32'd12_345_678, 32'd24_000_000, 0, '0},
         '{frds_pkg::KIND_SET, 32'd48_000_000, 32'd26_000_000, 0, '0},
         '{frds_pkg::KIND_ROUND, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, '0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      quiet_req = 1; quiet_rsp = 1;
      foreach (dir_tab[j])
         send_req(dir_tab[j].kind, dir_tab[j].target, dir_tab[j].parent,
                  dir_tab[j].has_exp, dir_tab[j].exp);
      set_config(5'd31, 5'd31, 1'b1, 1'b1);
      foreach (dir_tab[j])
         send_req(dir_tab[j].kind, dir_tab[j].target, dir_tab[j].parent, 1'b0, '0);
      set_config(5'd0, 5'd1, 1'b0, 1'b1);
      for (i = 0; i < 6; i++)
         send_req(2'(i % 3), rand_rate(i % 5), rand_rate(4 - i % 5), 1'b0, '0);

      // random phases over several settings
      for (k = 0; k < 10; k++) begin
         case (k)
            0: set_config(5'd8, 5'd8, 1'b0, 1'b0);
            1: set_config(5'd31, 5'd31, 1'b0, 1'b0);
            2: set_config(5'd1, 5'd1, 1'b1, 1'b0);
            3: set_config(5'd0, 5'd0, 1'b0, 1'b1);
            default: set_config(5'($urandom_range(31)), 5'($urandom_range(31)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));
         endcase
         quiet_req = (k == 4); quiet_rsp = (k == 4);
         for (i = 0; i < 75; i++) begin
            kind = ($urandom_range(99) < 5) ? frds_pkg::KIND_SPARE
                                            : 2'($urandom_range(2));
            p = rand_rate($urandom_range(4));
            t = rand_rate($urandom_range(4));
            if (kind == frds_pkg::KIND_ROUND && $urandom_range(3) != 0 && p > 1)
               t = $urandom_range(p - 1, 1);
            send_req(kind, t, p, 1'b0, '0);
         end
      end

      // drain
      quiet_rsp = 1;
      waited = 0;
      while (ratio_q.size() != 0 && waited < 100_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (errors == 0 && ratio_q.size() == 0)
         $display("fractional_divider_ratio_solver_core verification clean");
      else
         $display("fractional_divider_ratio_solver_core verification failed");
      $finish;
   end

endmodule
